FILE: src/bjse_pkg.sv
// Shared types, constants and character functions for the JSON string encoder.
package bjse_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [15:0] CapacityReset = 16'd64;
  localparam logic [16:0] Headroom      = 17'd6;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNul       = 8'h00;
  localparam logic [7:0] CharUpperA    = 8'h41;
  localparam logic [7:0] CtrlLimit     = 8'h20;
  localparam logic [7:0] HighLimit     = 8'h80;
  localparam logic [7:0] Utf8Lead      = 8'hC0;
  localparam logic [7:0] Utf8Cont      = 8'h80;
  localparam logic [7:0] LowMask       = 8'h3F;

  localparam logic [2:0] AddrCapacity = 3'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        end_of_string;
    logic [15:0] total_length;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_ESC,
    KIND_CTRL,
    KIND_UTF8
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] length;
  } desc_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CharZero + {4'd0, v};
    end else begin
      r = CharUpperA + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [2:0] kind_len(input kind_e k);
    logic [2:0] r;
    case (k)
      KIND_PLAIN: r = 3'd1;
      KIND_ESC:   r = 3'd2;
      KIND_CTRL:  r = 3'd6;
      KIND_UTF8:  r = 3'd2;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] esc_char(input kind_e k, input logic [7:0] b,
                                          input logic [2:0] idx);
    logic [7:0] r;
    r = CharNul;
    case (k)
      KIND_PLAIN: r = b;
      KIND_ESC:   r = (idx == 3'd0) ? CharBackslash : b;
      KIND_UTF8:  r = (idx == 3'd0) ? (Utf8Lead | {6'd0, b[7:6]}) : (Utf8Cont | (b & LowMask));
      KIND_CTRL: begin
        case (idx)
          3'd0:    r = CharBackslash;
          3'd1:    r = CharU;
          3'd2:    r = CharZero;
          3'd3:    r = CharZero;
          3'd4:    r = hex_digit(b[7:4]);
          3'd5:    r = hex_digit(b[3:0]);
          default: r = CharNul;
        endcase
      end
      default:    r = CharNul;
    endcase
    return r;
  endfunction

endpackage

FILE: src/bytes_to_json_string_encoder.sv
// Top level of the byte stream to JSON string text encoder.
//
// Input side is a queue: drive in_data_i and push; a byte is taken on a
// clock edge with push high and full low. Result side is a queue too: while
// empty is low the oldest character sits on out_data_o and pop takes it.
// A byte becomes one character (plain ASCII), two (quote, backslash, byte of
// 0x80 and above) or six (control byte); on a byte marked last a terminator
// follows with end_of_string set and total_length holding the string length.
// Once the count plus 6 reaches out_capacity, bytes are dropped.
// The first character of a byte passes through the queue and then the result
// register. Throughput: one character per cycle while pop is high, paced by the
// result register, so one byte per cycle for plain bytes; an expanding byte
// holds the back end until its characters are out and the queue of QueueDepth
// entries absorbs that until full rises. A stalled receiver holds the result
// register, the queue fills and full stops the sender.
// Reset empties the queue and result register, clears the count and sets
// out_capacity to 64. out_capacity is the APB register at byte address 0.
module bytes_to_json_string_encoder #(
  parameter int unsigned QueueDepth = bjse_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  bjse_pkg::in_item_t  in_data_i,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output bjse_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]     capacity_q, capacity_d;
  logic            q_push, q_full, q_pop, q_empty;
  bjse_pkg::desc_t q_in, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == bjse_pkg::AddrCapacity) ? {16'd0, capacity_q} : 32'd0;

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && paddr == bjse_pkg::AddrCapacity) begin
      capacity_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= bjse_pkg::CapacityReset;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  bjse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_data_i),
    .capacity_i (capacity_q),
    .q_full_i   (q_full),
    .full_o     (full),
    .q_push_o   (q_push),
    .q_desc_o   (q_in)
  );

  bjse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  bjse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_data_o)
  );

endmodule

FILE: src/bjse_front.sv
// Front end: accepts bytes, classifies them, applies the capacity test and keeps the count.
module bjse_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bjse_pkg::in_item_t   in_item_i,
  input  logic [15:0]          capacity_i,
  input  logic                 q_full_i,
  output logic                 full_o,
  output logic                 q_push_o,
  output bjse_pkg::desc_t      q_desc_o
);

  logic [15:0]     count_q, count_d;
  logic            accept;
  logic            room;
  bjse_pkg::kind_e kind;
  logic [2:0]      n_chars;
  logic [15:0]     new_count;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;
  assign room   = ({1'b0, count_q} + bjse_pkg::Headroom) < {1'b0, capacity_i};

  always_comb begin
    kind = bjse_pkg::KIND_NONE;
    if (room) begin
      if (in_item_i.in_byte == bjse_pkg::CharQuote ||
          in_item_i.in_byte == bjse_pkg::CharBackslash) begin
        kind = bjse_pkg::KIND_ESC;
      end else if (in_item_i.in_byte < bjse_pkg::CtrlLimit) begin
        kind = bjse_pkg::KIND_CTRL;
      end else if (in_item_i.in_byte < bjse_pkg::HighLimit) begin
        kind = bjse_pkg::KIND_PLAIN;
      end else begin
        kind = bjse_pkg::KIND_UTF8;
      end
    end
  end

  assign n_chars   = bjse_pkg::kind_len(kind);
  assign new_count = count_q + {13'd0, n_chars};

  // drop bytes that produce nothing unless they close the string
  assign q_push_o = accept && (kind != bjse_pkg::KIND_NONE || in_item_i.last_byte);

  always_comb begin
    q_desc_o.kind   = kind;
    q_desc_o.data   = in_item_i.in_byte;
    q_desc_o.last   = in_item_i.last_byte;
    q_desc_o.length = new_count;
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = in_item_i.last_byte ? 16'd0 : new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 16'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

FILE: src/bjse_queue.sv
// Small register queue of classified bytes between front and back end.
module bjse_queue #(
  parameter int unsigned Depth = bjse_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bjse_pkg::desc_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bjse_pkg::desc_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bjse_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: src/bjse_back.sv
// Back end: expands each classified byte into characters and drives the result register.
module bjse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  bjse_pkg::desc_t     q_head_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output bjse_pkg::out_item_t out_item_o
);

  logic                valid_q, valid_d;
  logic [2:0]          idx_q, idx_d;
  bjse_pkg::out_item_t item_q, item_d;
  logic [2:0]          n_chars;
  logic [2:0]          total;
  logic                load;
  logic                final_beat;

  assign n_chars    = bjse_pkg::kind_len(q_head_i.kind);
  assign total      = n_chars + {2'd0, q_head_i.last};
  assign load       = !q_empty_i && (!valid_q || pop_i);
  assign final_beat = (idx_q == total - 3'd1);
  assign q_pop_o    = load && final_beat;
  assign empty_o    = !valid_q;
  assign out_item_o = item_q;

  always_comb begin
    if (idx_q == n_chars) begin
      item_d.out_char      = bjse_pkg::CharNul;
      item_d.end_of_string = 1'b1;
      item_d.total_length  = q_head_i.length;
    end else begin
      item_d.out_char      = bjse_pkg::esc_char(q_head_i.kind, q_head_i.data, idx_q);
      item_d.end_of_string = 1'b0;
      item_d.total_length  = 16'd0;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = final_beat ? 3'd0 : idx_q + 3'd1;
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: src/bjse_checker.sv
// Port-level checks for the JSON string encoder, bound to the top level.
module bjse_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pop,
  input logic                empty,
  input bjse_pkg::out_item_t out_data_i,
  input logic                pready
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_data_i))
    else $error("waiting result beat changed or vanished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_i.end_of_string |-> out_data_i.out_char == bjse_pkg::CharNul)
    else $error("terminator beat carries a character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_data_i.end_of_string |-> out_data_i.total_length == 16'd0)
    else $error("character beat carries a length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_data_i.end_of_string |-> out_data_i.out_char != bjse_pkg::CharNul)
    else $error("character beat carries NUL");

  assert property (@(posedge clk_i) pready)
    else $error("pready dropped");

endmodule

bind bytes_to_json_string_encoder bjse_checker u_bjse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pop        (pop),
  .empty      (empty),
  .out_data_i (out_data_o),
  .pready     (pready)
);
